[rtl/lms_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// lms_pkg - shared types and script table of the lift macro sequencer
// Item, state and register types, command codes and the fixed macro scripts.
// ---------------------------------------------------------------------------
package lms_pkg;

	localparam int unsigned STEPS_MAX = 3;
	localparam logic [14:0] ELAPSED_MAX = 15'h7FFF;

	typedef enum logic [2:0] {
		KIND_TICK         = 3'd0,
		KIND_START        = 3'd1,
		KIND_CANCEL       = 3'd2,
		KIND_MANUAL       = 3'd3,
		KIND_SET_PIVOT    = 3'd4,
		KIND_TOGGLE_PIVOT = 3'd5,
		KIND_SET_CLAW     = 3'd6,
		KIND_TOGGLE_CLAW  = 3'd7
	} kind_t;

	localparam logic [3:0] MAC_NONE        = 4'd0;
	localparam logic [3:0] MAC_INTAKE      = 4'd1;
	localparam logic [3:0] MAC_MATCHLOAD   = 4'd2;
	localparam logic [3:0] MAC_RAISE       = 4'd3;
	localparam logic [3:0] MAC_LOWER       = 4'd4;
	localparam logic [3:0] MAC_RAISE_FULL  = 4'd5;
	localparam logic [3:0] MAC_LOWER_FULL  = 4'd6;
	localparam logic [3:0] MAC_RAISE_CLEAR = 4'd7;
	localparam logic [3:0] MAC_LOWER_CLEAR = 4'd8;

	typedef enum logic [2:0] {
		REG_RAISE_DRIVE    = 3'd0,
		REG_LOWER_DRIVE    = 3'd1,
		REG_HOLD_DRIVE     = 3'd2,
		REG_CLEARANCE_TIME = 3'd3,
		REG_VALVE_DELAY    = 3'd4,
		REG_FULL_MOVE_TIME = 3'd5,
		REG_PIVOT_INTAKE   = 3'd6,
		REG_PIVOT_HOME     = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ACT_MOVE  = 2'd0,
		ACT_PIVOT = 2'd1,
		ACT_CLAW  = 2'd2
	} act_t;

	typedef enum logic [2:0] {
		VAL_RAISE  = 3'd0,
		VAL_LOWER  = 3'd1,
		VAL_INTAKE = 3'd2,
		VAL_HOME   = 3'd3,
		VAL_OPEN   = 3'd4,
		VAL_SHUT   = 3'd5
	} val_t;

	typedef enum logic [2:0] {
		DUR_CLEAR  = 3'd0,
		DUR_VALVE  = 3'd1,
		DUR_FULL   = 3'd2,
		DUR_FULL2  = 3'd3,
		DUR_CLEAR2 = 3'd4
	} dur_t;

	typedef struct packed {
		act_t act;
		val_t val;
		dur_t dur;
	} step_t;

	typedef struct packed {
		kind_t             kind;
		logic [3:0]        macro;
		logic signed [7:0] power;
		logic              level;
	} item_t;

	typedef struct packed {
		logic [6:0]        raise_drive;
		logic signed [7:0] lower_drive;
		logic [6:0]        hold_drive;
		logic [13:0]       clearance_time;
		logic [13:0]       valve_delay;
		logic [13:0]       full_move_time;
		logic              pivot_intake_level;
		logic              pivot_home_level;
	} cfg_t;

	typedef struct packed {
		logic [3:0]        active_macro;
		logic [1:0]        step_number;
		logic              step_begun;
		logic [14:0]       elapsed_ms;
		logic signed [7:0] motor_drive;
		logic              pivot_level;
		logic              claw_level;
	} state_t;

	localparam cfg_t CFG_RESET = '{
		raise_drive:        7'd127,
		lower_drive:        -8'sd127,
		hold_drive:         7'd10,
		clearance_time:     14'd200,
		valve_delay:        14'd150,
		full_move_time:     14'd600,
		pivot_intake_level: 1'b1,
		pivot_home_level:   1'b0
	};

	function automatic logic [1:0] script_len(input logic [3:0] m);
		logic [1:0] n;
		case (m)
			MAC_INTAKE, MAC_MATCHLOAD, MAC_RAISE: n = 2'd3;
			MAC_LOWER: n = 2'd2;
			MAC_RAISE_FULL, MAC_LOWER_FULL, MAC_RAISE_CLEAR, MAC_LOWER_CLEAR: n = 2'd1;
			default: n = 2'd0;
		endcase
		return n;
	endfunction

	function automatic step_t script_step(input logic [3:0] m, input logic [1:0] idx);
		step_t s;
		s = '{act: ACT_MOVE, val: VAL_RAISE, dur: DUR_CLEAR};
		case (m)
			MAC_INTAKE, MAC_MATCHLOAD: begin
				case (idx)
					2'd0: s = '{act: ACT_MOVE, val: VAL_RAISE, dur: DUR_CLEAR};
					2'd1: s = '{act: ACT_PIVOT,
						val: (m == MAC_INTAKE) ? VAL_INTAKE : VAL_HOME, dur: DUR_VALVE};
					default: s = '{act: ACT_CLAW, val: VAL_OPEN, dur: DUR_VALVE};
				endcase
			end
			MAC_RAISE: begin
				case (idx)
					2'd0: s = '{act: ACT_CLAW, val: VAL_SHUT, dur: DUR_VALVE};
					2'd1: s = '{act: ACT_PIVOT, val: VAL_HOME, dur: DUR_VALVE};
					default: s = '{act: ACT_MOVE, val: VAL_RAISE, dur: DUR_FULL};
				endcase
			end
			MAC_LOWER: begin
				case (idx)
					2'd0: s = '{act: ACT_PIVOT, val: VAL_HOME, dur: DUR_VALVE};
					default: s = '{act: ACT_MOVE, val: VAL_LOWER, dur: DUR_FULL2};
				endcase
			end
			MAC_RAISE_FULL:  s = '{act: ACT_MOVE, val: VAL_RAISE, dur: DUR_FULL};
			MAC_LOWER_FULL:  s = '{act: ACT_MOVE, val: VAL_LOWER, dur: DUR_FULL2};
			MAC_RAISE_CLEAR: s = '{act: ACT_MOVE, val: VAL_RAISE, dur: DUR_CLEAR};
			MAC_LOWER_CLEAR: s = '{act: ACT_MOVE, val: VAL_LOWER, dur: DUR_CLEAR2};
			default: s = '{act: ACT_MOVE, val: VAL_RAISE, dur: DUR_CLEAR};
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

[rtl/lms_step.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// lms_step - next-state logic of the lift macro sequencer
// Applies one request to the sequencer state: tick, macro start, cancel,
// manual drive or valve command.
// ---------------------------------------------------------------------------
module lms_step import lms_pkg::*; (
	input  wire cfg_t   cfg,
	input  wire state_t cur,
	input  wire item_t  item,
	output state_t      nxt
);

	function automatic logic [14:0] dur_ms(input dur_t d, input cfg_t c);
		logic [14:0] v;
		case (d)
			DUR_CLEAR: v = {1'b0, c.clearance_time};
			DUR_VALVE: v = {1'b0, c.valve_delay};
			DUR_FULL:  v = {1'b0, c.full_move_time};
			DUR_FULL2: v = {c.full_move_time, 1'b0};
			default:   v = {c.clearance_time, 1'b0};
		endcase
		return v;
	endfunction

	always_comb begin
		state_t s;
		step_t  stp;
		logic   done;
		logic   was_busy;
		s = cur;
		done = 1'b0;
		stp = script_step(MAC_NONE, 2'd0);
		was_busy = cur.active_macro != MAC_NONE;
		case (item.kind)
			KIND_TICK: begin
				if (s.step_begun && s.elapsed_ms != ELAPSED_MAX)
					s.elapsed_ms = s.elapsed_ms + 15'd1;
				// up to STEPS_MAX steps complete per pass; zero durations chain steps
				for (int i = 0; i < STEPS_MAX; i++) begin
					if (s.active_macro != MAC_NONE && !done) begin
						if (s.step_number >= script_len(s.active_macro)) begin
							s.active_macro = MAC_NONE;
							s.step_number = 2'd0;
							s.step_begun = 1'b0;
							done = 1'b1;
						end else begin
							stp = script_step(s.active_macro, s.step_number);
							if (!s.step_begun) begin
								case (stp.act)
									ACT_MOVE: s.motor_drive = (stp.val == VAL_RAISE) ?
										{1'b0, cfg.raise_drive} : cfg.lower_drive;
									ACT_PIVOT: s.pivot_level = (stp.val == VAL_INTAKE) ?
										cfg.pivot_intake_level : cfg.pivot_home_level;
									default: s.claw_level = stp.val == VAL_OPEN;
								endcase
								s.elapsed_ms = '0;
								s.step_begun = 1'b1;
							end
							if (s.elapsed_ms < dur_ms(stp.dur, cfg)) begin
								done = 1'b1;
							end else begin
								if (stp.act == ACT_MOVE)
									s.motor_drive = (s.motor_drive > 8'sd0) ?
										{1'b0, cfg.hold_drive} : 8'sd0;
								s.step_number = s.step_number + 2'd1;
								s.step_begun = 1'b0;
								if (s.step_number >= script_len(s.active_macro)) begin
									s.active_macro = MAC_NONE;
									s.step_number = 2'd0;
									done = 1'b1;
								end
							end
						end
					end
				end
			end
			KIND_START: begin
				if (item.macro == MAC_NONE && was_busy)
					s.motor_drive = 8'sd0;
				// unknown codes leave the sequencer idle
				s.active_macro = (script_len(item.macro) != 2'd0) ? item.macro : MAC_NONE;
				s.step_number = 2'd0;
				s.step_begun = 1'b0;
			end
			KIND_CANCEL: begin
				if (was_busy)
					s.motor_drive = 8'sd0;
				s.active_macro = MAC_NONE;
				s.step_number = 2'd0;
				s.step_begun = 1'b0;
			end
			KIND_MANUAL: begin
				if (item.power != 8'sd0) begin
					s.active_macro = MAC_NONE;
					s.step_number = 2'd0;
					s.step_begun = 1'b0;
					s.motor_drive = item.power;
				end else if (!was_busy) begin
					s.motor_drive = 8'sd0;
				end
			end
			KIND_SET_PIVOT:    s.pivot_level = item.level;
			KIND_TOGGLE_PIVOT: s.pivot_level = ~s.pivot_level;
			KIND_SET_CLAW:     s.claw_level = item.level;
			KIND_TOGGLE_CLAW:  s.claw_level = ~s.claw_level;
			default: s = cur;
		endcase
		nxt = s;
	end

endmodule
`default_nettype wire

[rtl/lift_macro_sequencer.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// lift_macro_sequencer - timed actuator sequencer for lift motor and valves
// Runs fixed macro scripts of move, pivot and claw steps timed by 1 ms ticks;
// every request returns one status result.
// ---------------------------------------------------------------------------
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   tuser: kind; tdata: macro, power, level
//  m_*       out  m_tvalid/m_tready   tdata: motor_power, pivot, claw, busy
//  cfg_*     in   cfg_we              cfg_index, cfg_wdata
//
//  One request per cycle sustained while m_tready is high: an input
//  register, one pass of next-state logic, then the result register.
//  Zero-duration steps chain inside that one pass (up to three steps).
//  Reset clears the sequencer state and loads the register defaults.
//  A stalled result holds; one more request is taken into the input register.
// ---------------------------------------------------------------------------
module lift_macro_sequencer import lms_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,   // [3:0] macro, [11:4] power, [12] level, [15:13] zero
	input  wire  [2:0]  s_tuser,   // [2:0] kind
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,   // [7:0] motor_power, [8] pivot_out, [9] claw_out,
	                               // [10] busy_res, [15:11] zero
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_index,
	input  wire  [13:0] cfg_wdata
);

	logic        v_s1;
	item_t       item_s1;
	cfg_t        cfg_q;
	state_t      st_q;
	state_t      st_nxt;
	logic        out_v_q;
	logic [15:0] out_data_q;
	logic        adv;

	assign adv      = v_s1 && (!out_v_q || m_tready);
	assign s_tready = !v_s1 || adv;
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.kind  <= kind_t'(s_tuser);
			item_s1.macro <= s_tdata[3:0];
			item_s1.power <= s_tdata[11:4];
			item_s1.level <= s_tdata[12];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				REG_RAISE_DRIVE:    cfg_q.raise_drive <= cfg_wdata[6:0];
				REG_LOWER_DRIVE:    cfg_q.lower_drive <= cfg_wdata[7:0];
				REG_HOLD_DRIVE:     cfg_q.hold_drive <= cfg_wdata[6:0];
				REG_CLEARANCE_TIME: cfg_q.clearance_time <= cfg_wdata;
				REG_VALVE_DELAY:    cfg_q.valve_delay <= cfg_wdata;
				REG_FULL_MOVE_TIME: cfg_q.full_move_time <= cfg_wdata;
				REG_PIVOT_INTAKE:   cfg_q.pivot_intake_level <= cfg_wdata[0];
				REG_PIVOT_HOME:     cfg_q.pivot_home_level <= cfg_wdata[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	lms_step u_step (
		.cfg  (cfg_q),
		.cur  (st_q),
		.item (item_s1),
		.nxt  (st_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (adv)
				st_q <= st_nxt;
			if (adv)
				out_v_q <= 1'b1;
			else if (m_tready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			out_data_q <= {5'b0, st_nxt.active_macro != MAC_NONE, st_nxt.claw_level,
				st_nxt.pivot_level, st_nxt.motor_drive};
	end

`ifndef SYNTHESIS
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.active_macro == MAC_NONE |-> !st_q.step_begun && st_q.step_number == 2'd0)
		else $error("idle sequencer holds step state");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.active_macro != MAC_NONE |-> st_q.step_number < script_len(st_q.active_macro))
		else $error("step number beyond script length");

	a_busy_match: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_data_q[10] == (st_q.active_macro != MAC_NONE))
		else $error("busy flag does not match state");

	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_v_q)
		else $error("processed request produced no result");

	a_stall_state: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(st_q))
		else $error("state changed without a request");
`endif

endmodule
`default_nettype wire
